// ----- sv/mwsm_pkg.sv -----
package mwsm_pkg;

	// quotient bits of the wheel divide; every result magnitude is below 2**15
	localparam int QBITS     = 15;
	// clamp / multiply / sum / max / scale stages ahead of the divider
	localparam int FRONT_STG = 5;
	// front stages, divide stages, output register
	localparam int NSTG      = FRONT_STG + QBITS + 1;
	// wheel sum magnitude and scaled dividend widths
	localparam int MAGW      = 31;
	localparam int AW        = 46;
	localparam int LWW       = 28;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;

	localparam logic [CFG_IW-1:0] REG_CENTER_OFFSET_X = 3'd0;
	localparam logic [CFG_IW-1:0] REG_CENTER_OFFSET_Y = 3'd1;
	localparam logic [CFG_IW-1:0] REG_WHEELBASE_SUM   = 3'd2;
	localparam logic [CFG_IW-1:0] REG_LIMIT_X         = 3'd3;
	localparam logic [CFG_IW-1:0] REG_LIMIT_Y         = 3'd4;
	localparam logic [CFG_IW-1:0] REG_LIMIT_SPIN      = 3'd5;
	localparam logic [CFG_IW-1:0] REG_WHEEL_LIMIT     = 3'd6;

	typedef struct packed {
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] vel_spin;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] wheel_speed_a;
		logic signed [15:0] wheel_speed_b;
		logic signed [15:0] wheel_speed_c;
		logic signed [15:0] wheel_speed_d;
	} wheel_t;

	typedef struct packed {
		logic signed [12:0] center_offset_x;
		logic signed [12:0] center_offset_y;
		logic [12:0]        wheelbase_sum;
		logic [14:0]        limit_x;
		logic [14:0]        limit_y;
		logic [14:0]        limit_spin;
		logic [14:0]        wheel_limit;
	} cfg_t;

	// front end to divider: per-lane dividend and sign, shared divisor
	typedef struct packed {
		logic [3:0][AW-1:0] dividend;
		logic [MAGW-1:0]    divisor;
		logic [3:0]         neg;
	} front_t;

	// divider result: per-lane quotient magnitude and sign
	typedef struct packed {
		logic [3:0][QBITS-1:0] quot;
		logic [3:0]            neg;
	} quot_t;

endpackage

// ----- sv/mecanum_wheel_speed_mix.sv -----
// Mecanum wheel speed mixer: chassis command (x, y, spin) in, four wheel speeds out.
//
// Channels:
//   cmd    - command word in; accepted on a clock edge with cmd_valid high, cmd_stall low.
//   wheel  - wheel speed word out; taken on an edge with wheel_valid high, wheel_stall low.
//   cfg    - register writes (cfg_index, cfg_data), taken when cfg_valid is high;
//            cfg_ready is always high. Write only while no word is in flight.
//
// Pipeline: 5 front stages of clamp, multiply, sum, max and scale, 15 restoring divide
// stages of one quotient bit each, then the output register. Throughput: one word per
// cycle while the skid register is empty.
//
// Stall: the pipeline moves as a whole. If the output word is stalled, it is moved into
// a skid register and one more word is taken in; only while the skid holds a word is the
// pipeline frozen and cmd_stall high. Nothing is dropped or repeated.
//
// Reset (arst_n low): all valid bits and the skid clear, registers go to their
// defaults (offsets 0, wheelbase 400, all limits 8000).
module mecanum_wheel_speed_mix (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cmd_valid,
	output logic                                  cmd_stall,
	input  mwsm_pkg::cmd_t                        cmd,
	output logic                                  wheel_valid,
	input  logic                                  wheel_stall,
	output mwsm_pkg::wheel_t                      wheel,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mwsm_pkg::CFG_IW-1:0]           cfg_index,
	input  logic [mwsm_pkg::CFG_DW-1:0]           cfg_data
);
	import mwsm_pkg::*;

	cfg_t            cfg_q;
	logic [NSTG-1:0] vld_q;
	logic            en;
	front_t          front;
	quot_t           quot;
	wheel_t          out_q;
	wheel_t          skid_q;
	logic            skid_vld_q;
	logic [15:0]     sgn [4];

	assign cfg_ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_offset_x <= '0;
			cfg_q.center_offset_y <= '0;
			cfg_q.wheelbase_sum   <= 13'd400;
			cfg_q.limit_x         <= 15'd8000;
			cfg_q.limit_y         <= 15'd8000;
			cfg_q.limit_spin      <= 15'd8000;
			cfg_q.wheel_limit     <= 15'd8000;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CENTER_OFFSET_X: cfg_q.center_offset_x <= cfg_data[12:0];
				REG_CENTER_OFFSET_Y: cfg_q.center_offset_y <= cfg_data[12:0];
				REG_WHEELBASE_SUM:   cfg_q.wheelbase_sum   <= cfg_data[12:0];
				REG_LIMIT_X:         cfg_q.limit_x         <= cfg_data[14:0];
				REG_LIMIT_Y:         cfg_q.limit_y         <= cfg_data[14:0];
				REG_LIMIT_SPIN:      cfg_q.limit_spin      <= cfg_data[14:0];
				REG_WHEEL_LIMIT:     cfg_q.wheel_limit     <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless the skid is occupied
	assign en        = !skid_vld_q;
	assign cmd_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], cmd_valid};
		end
	end

	mwsm_front u_front (
		.clk (clk),
		.en  (en),
		.cmd (cmd),
		.cfg (cfg_q),
		.res (front)
	);

	mwsm_div u_div (
		.clk  (clk),
		.en   (en),
		.din  (front),
		.dout (quot)
	);

	// restore sign; truncation toward zero falls out of sign-magnitude divide
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			sgn[l] = quot.neg[l] ? 16'(17'd0 - {2'b00, quot.quot[l]})
			                     : {1'b0, quot.quot[l]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.wheel_speed_a <= sgn[0];
			out_q.wheel_speed_b <= sgn[1];
			out_q.wheel_speed_c <= sgn[2];
			out_q.wheel_speed_d <= sgn[3];
		end
	end

	// skid: holds the older word when the output stalls while the pipe moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (!wheel_stall) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_q[NSTG-1] && wheel_stall) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q && vld_q[NSTG-1] && wheel_stall) begin
			skid_q <= out_q;
		end
	end

	assign wheel_valid = skid_vld_q | vld_q[NSTG-1];
	assign wheel       = skid_vld_q ? skid_q : out_q;

endmodule

// ----- sv/mwsm_front.sv -----
module mwsm_front (
	input  logic            clk,
	input  logic            en,
	input  mwsm_pkg::cmd_t  cmd,
	input  mwsm_pkg::cfg_t  cfg,
	output mwsm_pkg::front_t res
);
	import mwsm_pkg::*;

	function automatic logic signed [15:0] clampv(input logic signed [15:0] v,
		input logic [14:0] l);
		logic signed [16:0] lv;
		logic signed [16:0] vv;
		logic signed [16:0] nl;
		lv = $signed({2'b00, l});
		vv = $signed({v[15], v});
		nl = -lv;
		if (vv > lv) begin
			return $signed({1'b0, l});
		end else if (vv < nl) begin
			return nl[15:0];
		end
		return v;
	endfunction

	logic [12:0]        weff;
	logic signed [15:0] cx, cy, cs;
	logic signed [16:0] lin [4];
	logic signed [14:0] oxe, oye;
	logic signed [14:0] dd [4];
	logic signed [15:0] wd [4];

	logic signed [16:0] lin_s1 [4];
	logic signed [15:0] wd_s1 [4];
	logic signed [15:0] cs_s1;

	logic signed [31:0] p1_s2 [4];
	logic signed [31:0] p2_s2 [4];

	logic [MAGW-1:0] mag_s3 [4];
	logic [3:0]      neg_s3;

	logic [MAGW-1:0] mx01, mx23, mx;
	logic [LWW-1:0]  lw_q;
	logic [MAGW-1:0] mag_s4 [4];
	logic [3:0]      neg_s4;
	logic [MAGW-1:0] mx_s4;
	logic            scale_s4;

	logic [3:0][AW-1:0] a_s5;
	logic [MAGW-1:0]    dvs_s5;
	logic [3:0]         neg_s5;

	assign weff = (cfg.wheelbase_sum == 13'd0) ? 13'd1 : cfg.wheelbase_sum;

	// stage 1: clamp, linear mixes, spin lever arms
	always_comb begin
		cx = clampv(cmd.vel_x, cfg.limit_x);
		cy = clampv(cmd.vel_y, cfg.limit_y);
		cs = clampv(cmd.vel_spin, cfg.limit_spin);
		lin[0] = {cx[15], cx} + {cy[15], cy};
		lin[1] = {cx[15], cx} - {cy[15], cy};
		lin[2] = -{cx[15], cx} - {cy[15], cy};
		lin[3] = -{cx[15], cx} + {cy[15], cy};
		oxe = {{2{cfg.center_offset_x[12]}}, cfg.center_offset_x};
		oye = {{2{cfg.center_offset_y[12]}}, cfg.center_offset_y};
		dd[0] = oxe - oye;
		dd[1] = -oxe - oye;
		dd[2] = -oxe + oye;
		dd[3] = oxe + oye;
		for (int l = 0; l < 4; l++) begin
			wd[l] = $signed({3'b000, weff}) - {dd[l][14], dd[l]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s1 <= cs;
			for (int l = 0; l < 4; l++) begin
				lin_s1[l] <= lin[l];
				wd_s1[l]  <= wd[l];
			end
		end
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				p1_s2[l] <= 32'(lin_s1[l]) * 32'($signed({1'b0, weff}));
				p2_s2[l] <= 32'(cs_s1) * 32'(wd_s1[l]);
			end
		end
	end

	// stage 3: wheel numerators as sign and magnitude
	always_ff @(posedge clk) begin
		logic signed [31:0] n;
		logic [31:0]        m;
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				n = p1_s2[l] + p2_s2[l];
				m = n[31] ? 32'(-n) : 32'(n);
				mag_s3[l] <= m[MAGW-1:0];
				neg_s3[l] <= n[31];
			end
		end
	end

	// wheel_limit * wheelbase, static while items run
	always_ff @(posedge clk) begin
		lw_q <= LWW'(cfg.wheel_limit * weff);
	end

	// stage 4: largest magnitude and scale decision
	always_comb begin
		mx01 = (mag_s3[0] > mag_s3[1]) ? mag_s3[0] : mag_s3[1];
		mx23 = (mag_s3[2] > mag_s3[3]) ? mag_s3[2] : mag_s3[3];
		mx   = (mx01 > mx23) ? mx01 : mx23;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s4    <= mx;
			scale_s4 <= mx > MAGW'(lw_q);
			neg_s4   <= neg_s3;
			for (int l = 0; l < 4; l++) begin
				mag_s4[l] <= mag_s3[l];
			end
		end
	end

	// stage 5: dividend and divisor
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s5 <= neg_s4;
			dvs_s5 <= scale_s4 ? mx_s4 : MAGW'(weff);
			for (int l = 0; l < 4; l++) begin
				a_s5[l] <= scale_s4 ? AW'(mag_s4[l] * cfg.wheel_limit) : AW'(mag_s4[l]);
			end
		end
	end

	assign res.dividend = a_s5;
	assign res.divisor  = dvs_s5;
	assign res.neg      = neg_s5;

endmodule

// ----- sv/mwsm_div.sv -----
module mwsm_div (
	input  logic              clk,
	input  logic              en,
	input  mwsm_pkg::front_t  din,
	output mwsm_pkg::quot_t   dout
);
	import mwsm_pkg::*;

	// one quotient bit per stage, msb first
	logic [QBITS-1:0][3:0][AW-1:0]    rem_st;
	logic [QBITS-1:0][3:0][QBITS-1:0] q_st;
	logic [QBITS-1:0][MAGW-1:0]       dvs_st;
	logic [QBITS-1:0][3:0]            neg_st;

	for (genvar j = 0; j < QBITS; j++) begin : g_stg
		localparam int K = QBITS - 1 - j;
		logic [3:0][AW-1:0]    rin;
		logic [3:0][QBITS-1:0] qin;
		logic [MAGW-1:0]       dvin;
		logic [3:0]            nin;
		logic [AW-1:0]         sh;
		logic [3:0][AW-1:0]    rnx;
		logic [3:0][QBITS-1:0] qnx;

		if (j == 0) begin : g_first
			assign rin  = din.dividend;
			assign qin  = '0;
			assign dvin = din.divisor;
			assign nin  = din.neg;
		end else begin : g_next
			assign rin  = rem_st[j-1];
			assign qin  = q_st[j-1];
			assign dvin = dvs_st[j-1];
			assign nin  = neg_st[j-1];
		end

		always_comb begin
			sh = AW'(dvin) << K;
			for (int l = 0; l < 4; l++) begin
				qnx[l] = qin[l];
				if (rin[l] >= sh) begin
					rnx[l]    = rin[l] - sh;
					qnx[l][K] = 1'b1;
				end else begin
					rnx[l] = rin[l];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[j] <= rnx;
				q_st[j]   <= qnx;
				dvs_st[j] <= dvin;
				neg_st[j] <= nin;
			end
		end
	end

	assign dout.quot = q_st[QBITS-1];
	assign dout.neg  = neg_st[QBITS-1];

endmodule
